FILE: rtl/gcba_pkg.sv
// ----------------------------------------------------------------------------
// gcba_pkg
// Shared types and constants for the grid column block accumulator: register
// indexes, reset values, field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
package gcba_pkg;

  // Default sizes of the column store
  localparam int NUM_BINS_DEF    = 256;
  localparam int NUM_SPECIES_DEF = 4;

  // Fixed field widths
  localparam int OFS_W   = 24;   // offsets and heights
  localparam int CNT_W   = 10;   // per-species and total counts
  localparam int BINS_W  = 9;    // bins_x / bins_y
  localparam int BIN_W   = 8;    // bin_index output
  localparam int SP_W    = 2;    // species index
  localparam int PROD_W  = 48;   // offset times reciprocal
  localparam int FRAC_W  = 16;   // fraction bits of the reciprocal
  localparam int POS_W   = PROD_W - FRAC_W;
  localparam int COL_W   = 2 * BINS_W;
  localparam int SPECIES_SLOTS = 4;

  // Stream and config port widths
  localparam int IN_TDATA_W  = 3 * OFS_W;                              // 72
  localparam int IN_TUSER_W  = SP_W;
  localparam int OUT_TDATA_W = BIN_W + 2 * OFS_W + SPECIES_SLOTS * CNT_W; // 96
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BINS_X      = 3'd0,
    REG_BINS_Y      = 3'd1,
    REG_RECIP_LEN_X = 3'd2,
    REG_RECIP_LEN_Y = 3'd3,
    REG_BLOCK_SIZE  = 3'd4,
    REG_MIN_EXTENT  = 3'd5,
    REG_MAX_EXTENT  = 3'd6
  } cfg_reg_t;

  // Register reset values
  localparam logic [BINS_W-1:0] BINS_RST       = 9'd16;
  localparam logic [OFS_W-1:0]  RECIP_RST      = 24'd65536;
  localparam logic [CNT_W-1:0]  BLOCK_SIZE_RST = 10'd10;
  localparam logic [OFS_W-1:0]  MIN_EXT_RST    = 24'd0;
  localparam logic [OFS_W-1:0]  MAX_EXT_RST    = 24'hFFFFFF;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_INDEX,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic in_ready;   // input register may take a beat
    logic in_load;    // capture the input beat
    logic clr_wr;     // write one zero row of the clearing pass
    logic rd_en;      // read the column row
    logic rmw_wr;     // write back the updated column row
    logic out_load;   // load the result register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing pass at its last row
    logic drop;       // hit maps outside the store or species range
    logic emit;       // update completes a block within extent
    logic out_free;   // result register can take a new result
  } dp_status_t;

endpackage

FILE: rtl/grid_column_block_accumulator_core.sv
// ----------------------------------------------------------------------------
// grid_column_block_accumulator_core
// Bins sorted hits into 2-D grid columns, counts species per column and
// reports each column block once it holds block_size hits.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat contents (lowest bits first)
// s_axis    in   tdata: x_offset, y_offset, z_offset; tuser: species
// m_axis    out  tdata: bin_index, start_z, end_z, count_0..count_3
// cfg       in   cfg_we / cfg_index / cfg_data, register writes
//
// A hit is taken only once the last one is through: the controller walks
// multiply, clamp, index, column store read and write-back, with one read
// and one write port; a dropped hit skips the read and write-back.
// After reset a clearing pass writes zeros to every column with
// s_axis_tready low; config writes are taken meanwhile.
// A result waits in the output register; a new hit is taken meanwhile, and
// only a second finished block stalls in the update step until it drains.
// ----------------------------------------------------------------------------
module grid_column_block_accumulator_core #(
  parameter int NUM_BINS    = gcba_pkg::NUM_BINS_DEF,
  parameter int NUM_SPECIES = gcba_pkg::NUM_SPECIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // hit stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gcba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // x_offset, y_offset, z_offset
  input  logic [gcba_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // species
  // block stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bin_index, start_z, end_z, count_0, count_1, count_2, count_3
  output logic [gcba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // config writes
  input  logic                              cfg_we,
  input  logic [gcba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcba_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import gcba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  gcba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .status   (status),
    .cmd      (cmd)
  );

  gcba_dpath #(
    .NUM_BINS    (NUM_BINS),
    .NUM_SPECIES (NUM_SPECIES)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .status    (status)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

FILE: rtl/gcba_ram.sv
// ----------------------------------------------------------------------------
// gcba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/gcba_ctrl.sv
// ----------------------------------------------------------------------------
// gcba_ctrl
// Controller: clearing pass after reset, then one hit at a time through
// multiply, clamp, index, store read and read-modify-write update.
// ----------------------------------------------------------------------------
module gcba_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  gcba_pkg::dp_status_t   status,
  output gcba_pkg::ctrl_cmd_t    cmd
);

  import gcba_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_INDEX;
      ST_INDEX: state_next = ST_READ;
      ST_READ: begin
        if (status.drop) begin
          state_next = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold while a finished block waits for the result register
        if (!status.emit || status.out_free) begin
          cmd.rmw_wr   = 1'b1;
          cmd.out_load = status.emit;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

FILE: rtl/gcba_dpath.sv
// ----------------------------------------------------------------------------
// gcba_dpath
// Datapath: config registers, bin coordinate arithmetic, column store with
// its read-modify-write update, and the result register.
// ----------------------------------------------------------------------------
module gcba_dpath #(
  parameter int NUM_BINS    = gcba_pkg::NUM_BINS_DEF,
  parameter int NUM_SPECIES = gcba_pkg::NUM_SPECIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                cfg_we,
  input  logic [gcba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gcba_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input payload
  input  logic [gcba_pkg::IN_TDATA_W-1:0]     in_data,
  input  logic [gcba_pkg::IN_TUSER_W-1:0]     in_user,
  // result
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gcba_pkg::OUT_TDATA_W-1:0]    out_data,
  // control link
  input  gcba_pkg::ctrl_cmd_t                 cmd,
  output gcba_pkg::dp_status_t                status
);

  import gcba_pkg::*;

  localparam int AW     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNTS_W = NUM_SPECIES * CNT_W;
  localparam int WORD_W = CNTS_W + CNT_W + OFS_W;

  // config registers
  logic [BINS_W-1:0] bins_x, bins_y;
  logic [OFS_W-1:0]  recip_x, recip_y, min_ext, max_ext;
  logic [CNT_W-1:0]  block_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_x     <= BINS_RST;
      bins_y     <= BINS_RST;
      recip_x    <= RECIP_RST;
      recip_y    <= RECIP_RST;
      block_size <= BLOCK_SIZE_RST;
      min_ext    <= MIN_EXT_RST;
      max_ext    <= MAX_EXT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BINS_X:      bins_x     <= cfg_data[BINS_W-1:0];
        REG_BINS_Y:      bins_y     <= cfg_data[BINS_W-1:0];
        REG_RECIP_LEN_X: recip_x    <= cfg_data[OFS_W-1:0];
        REG_RECIP_LEN_Y: recip_y    <= cfg_data[OFS_W-1:0];
        REG_BLOCK_SIZE:  block_size <= cfg_data[CNT_W-1:0];
        REG_MIN_EXTENT:  min_ext    <= cfg_data[OFS_W-1:0];
        REG_MAX_EXTENT:  max_ext    <= cfg_data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts act as one
  logic [BINS_W-1:0] nx, ny, lim_x, lim_y;
  logic [CNT_W-1:0]  need;
  assign nx    = (bins_x == '0) ? BINS_W'(1) : bins_x;
  assign ny    = (bins_y == '0) ? BINS_W'(1) : bins_y;
  assign lim_x = nx - BINS_W'(1);
  assign lim_y = ny - BINS_W'(1);
  assign need  = (block_size == '0) ? CNT_W'(1) : block_size;

  // input beat register
  logic [OFS_W-1:0] x_ofs, y_ofs, z_ofs;
  logic [SP_W-1:0]  sp;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      x_ofs <= in_data[OFS_W-1:0];
      y_ofs <= in_data[2*OFS_W-1:OFS_W];
      z_ofs <= in_data[3*OFS_W-1:2*OFS_W];
      sp    <= in_user;
    end
  end

  // stage 1: offset times reciprocal
  logic [PROD_W-1:0] prod_x, prod_y;
  always_ff @(posedge clk) begin
    prod_x <= {{(PROD_W-OFS_W){1'b0}}, x_ofs} * {{(PROD_W-OFS_W){1'b0}}, recip_x};
    prod_y <= {{(PROD_W-OFS_W){1'b0}}, y_ofs} * {{(PROD_W-OFS_W){1'b0}}, recip_y};
  end

  // stage 2: drop the fraction and clamp to the last bin
  logic [POS_W-1:0]  pos_x, pos_y;
  logic [BINS_W-1:0] bx, by;
  assign pos_x = prod_x[PROD_W-1:FRAC_W];
  assign pos_y = prod_y[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    bx <= (pos_x > {{(POS_W-BINS_W){1'b0}}, lim_x}) ? lim_x : pos_x[BINS_W-1:0];
    by <= (pos_y > {{(POS_W-BINS_W){1'b0}}, lim_y}) ? lim_y : pos_y[BINS_W-1:0];
  end

  // stage 3: row-major column index
  logic [COL_W-1:0] col, col_prod;
  assign col_prod = {{BINS_W{1'b0}}, bx} * {{BINS_W{1'b0}}, ny};
  always_ff @(posedge clk) begin
    col <= col_prod + {{BINS_W{1'b0}}, by};
  end

  assign status.drop = (col >= COL_W'(NUM_BINS)) ||
                       ({1'b0, sp} >= (SP_W+1)'(NUM_SPECIES));

  // clearing pass row counter
  logic [AW-1:0] clr_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end
  assign status.clr_last = (clr_cnt == AW'(NUM_BINS - 1));

  // column store: {start, total, counts}
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata, upd_word;

  assign ram_we    = cmd.clr_wr | cmd.rmw_wr;
  assign ram_waddr = cmd.clr_wr ? clr_cnt : col[AW-1:0];
  assign ram_wdata = cmd.clr_wr ? '0 : upd_word;

  gcba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_BINS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (col[AW-1:0]),
    .rdata (ram_rdata)
  );

  // update: bump the hit's species and the total
  logic [SPECIES_SLOTS-1:0][CNT_W-1:0] cnt_new;
  logic [SPECIES_SLOTS*CNT_W-1:0]      cnt_flat;
  logic [CNT_W-1:0] rd_total, total_new;
  logic [OFS_W-1:0] rd_start, height;
  logic             done;

  for (genvar k = 0; k < SPECIES_SLOTS; k++) begin : g_lane
    if (k < NUM_SPECIES) begin : g_used
      assign cnt_new[k] = ram_rdata[k*CNT_W +: CNT_W] +
                          ((sp == SP_W'(k)) ? CNT_W'(1) : CNT_W'(0));
    end else begin : g_unused
      assign cnt_new[k] = '0;
    end
  end
  assign cnt_flat = cnt_new;

  assign rd_total  = ram_rdata[CNTS_W +: CNT_W];
  assign rd_start  = ram_rdata[CNTS_W+CNT_W +: OFS_W];
  assign total_new = rd_total + CNT_W'(1);
  assign done      = (total_new == need);
  // unsorted hit gives zero height
  assign height    = (z_ofs >= rd_start) ? (z_ofs - rd_start) : '0;

  assign status.emit = done && (height >= min_ext) && (height <= max_ext);

  // completed column restarts at this hit
  assign upd_word = done ? {z_ofs, {(CNT_W+CNTS_W){1'b0}}}
                         : {rd_start, total_new, cnt_flat[CNTS_W-1:0]};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {cnt_flat, z_ofs, rd_start, col[BIN_W-1:0]};
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

FILE: rtl/gcba_checker.sv
// ----------------------------------------------------------------------------
// gcba_checker
// Port-level checks of the accumulator: reset clearing pass, one hit at a
// time, result latency and output hold under back-pressure.
// ----------------------------------------------------------------------------
module gcba_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [gcba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // clearing pass follows every reset, so no hit is taken right after it
  a_clear_after_rst: assert property (@(posedge clk)
    rst |=> !s_axis_tready)
    else $error("hit input ready right after reset");

  // one hit in flight: ready drops after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second hit taken while one is in flight");

  // a block result needs the full multiply, clamp, index, read sequence
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=>
      !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid) ##1
      !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
    else $error("result appeared too soon after a hit");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind grid_column_block_accumulator_core gcba_checker u_gcba_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/gcba_block_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gcba_block_checker
// Watches the hit, block and config channels of the column accumulator. It
// keeps its own column store and register copy, predicts the block beat
// (if any) for every accepted hit, and compares block beats in order.
// ----------------------------------------------------------------------------
module gcba_block_checker #(
  parameter int NUM_BINS    = gcba_pkg::NUM_BINS_DEF,
  parameter int NUM_SPECIES = gcba_pkg::NUM_SPECIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [gcba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // x_offset, y_offset, z_offset
  input  logic [gcba_pkg::IN_TUSER_W-1:0]   s_axis_tuser,  // species
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // bin_index, start_z, end_z, count_0, count_1, count_2, count_3
  input  logic [gcba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [gcba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcba_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                pending
);

  import gcba_pkg::*;

  // Block beat, lowest field in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0] count_3;
    logic [CNT_W-1:0] count_2;
    logic [CNT_W-1:0] count_1;
    logic [CNT_W-1:0] count_0;
    logic [OFS_W-1:0] end_z;
    logic [OFS_W-1:0] start_z;
    logic [BIN_W-1:0] bin_index;
  } block_t;

  // Register copy
  logic [BINS_W-1:0] bins_x, bins_y;
  logic [OFS_W-1:0]  recip_x, recip_y;
  logic [CNT_W-1:0]  block_size;
  logic [OFS_W-1:0]  min_ext, max_ext;

  // Column store copy
  logic [CNT_W-1:0] species_cnt [NUM_BINS][SPECIES_SLOTS];
  logic [CNT_W-1:0] column_total [NUM_BINS];
  logic [OFS_W-1:0] column_start [NUM_BINS];

  block_t expected_blocks [$];

  // Axis coordinate: (offset * recip) >> 16, clamped to the last bin
  function automatic logic [BINS_W-1:0] axis_coord(input logic [OFS_W-1:0] ofs,
                                                   input logic [OFS_W-1:0] recip,
                                                   input logic [BINS_W-1:0] nbins);
    logic [PROD_W-1:0] prod;
    logic [POS_W-1:0]  pos;
    logic [BINS_W-1:0] n;
    prod = PROD_W'(ofs) * PROD_W'(recip);
    pos  = prod[PROD_W-1:FRAC_W];
    n    = (nbins == 0) ? BINS_W'(1) : nbins;
    if (pos > POS_W'(n - BINS_W'(1))) pos = POS_W'(n - BINS_W'(1));
    return pos[BINS_W-1:0];
  endfunction

  // Count one hit into its column; queue a block when the column completes within extent
  task automatic accumulate_hit(input logic [OFS_W-1:0] xo, input logic [OFS_W-1:0] yo,
                                input logic [OFS_W-1:0] z, input logic [SP_W-1:0] sp);
    logic [BINS_W-1:0] bx, by, ny;
    int unsigned       col;
    logic [CNT_W-1:0]  need;
    logic [OFS_W-1:0]  height;
    block_t            blk;
    ny   = (bins_y == 0) ? BINS_W'(1) : bins_y;
    bx   = axis_coord(xo, recip_x, bins_x);
    by   = axis_coord(yo, recip_y, bins_y);
    col  = 32'(bx) * 32'(ny) + 32'(by);
    need = (block_size == 0) ? CNT_W'(1) : block_size;
    // hits outside the store or species range leave no trace
    if (col >= NUM_BINS || sp >= NUM_SPECIES) return;
    species_cnt[col][sp] = species_cnt[col][sp] + CNT_W'(1);
    column_total[col]    = column_total[col] + CNT_W'(1);
    if (column_total[col] == need) begin
      height = (z >= column_start[col]) ? z - column_start[col] : '0;
      if (height >= min_ext && height <= max_ext) begin
        blk.bin_index = col[BIN_W-1:0];
        blk.start_z   = column_start[col];
        blk.end_z     = z;
        blk.count_0   = species_cnt[col][0];
        blk.count_1   = (NUM_SPECIES > 1) ? species_cnt[col][1] : '0;
        blk.count_2   = (NUM_SPECIES > 2) ? species_cnt[col][2] : '0;
        blk.count_3   = (NUM_SPECIES > 3) ? species_cnt[col][3] : '0;
        expected_blocks = {expected_blocks, blk};
      end
      // column restarts at the completing hit either way
      column_start[col] = z;
      for (int k = 0; k < SPECIES_SLOTS; k++) species_cnt[col][k] = '0;
      column_total[col] = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [OFS_W-1:0] want,
                             input logic [OFS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    block_t got;
    block_t want;
    if (rst) begin
      bins_x     = BINS_RST;
      bins_y     = BINS_RST;
      recip_x    = RECIP_RST;
      recip_y    = RECIP_RST;
      block_size = BLOCK_SIZE_RST;
      min_ext    = MIN_EXT_RST;
      max_ext    = MAX_EXT_RST;
      for (int c = 0; c < NUM_BINS; c++) begin
        column_total[c] = '0;
        column_start[c] = '0;
        for (int k = 0; k < SPECIES_SLOTS; k++) species_cnt[c][k] = '0;
      end
      expected_blocks.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_BINS_X:      bins_x     = cfg_data[BINS_W-1:0];
          REG_BINS_Y:      bins_y     = cfg_data[BINS_W-1:0];
          REG_RECIP_LEN_X: recip_x    = cfg_data;
          REG_RECIP_LEN_Y: recip_y    = cfg_data;
          REG_BLOCK_SIZE:  block_size = cfg_data[CNT_W-1:0];
          REG_MIN_EXTENT:  min_ext    = cfg_data;
          REG_MAX_EXTENT:  max_ext    = cfg_data;
          default: ;
        endcase
      end
      // block beats first, so a hit taken in the same cycle cannot match
      if (m_axis_tvalid && m_axis_tready) begin
        got = block_t'(m_axis_tdata);
        if (expected_blocks.size() == 0) begin
          $error("block beat with none expected: bin_index %0d", got.bin_index);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          check_field("bin_index", OFS_W'(want.bin_index), OFS_W'(got.bin_index));
          check_field("start_z",   want.start_z,           got.start_z);
          check_field("end_z",     want.end_z,             got.end_z);
          check_field("count_0",   OFS_W'(want.count_0),   OFS_W'(got.count_0));
          check_field("count_1",   OFS_W'(want.count_1),   OFS_W'(got.count_1));
          check_field("count_2",   OFS_W'(want.count_2),   OFS_W'(got.count_2));
          check_field("count_3",   OFS_W'(want.count_3),   OFS_W'(got.count_3));
        end
      end
      // hit beats
      if (s_axis_tvalid && s_axis_tready)
        accumulate_hit(s_axis_tdata[OFS_W-1:0], s_axis_tdata[2*OFS_W-1:OFS_W],
                       s_axis_tdata[3*OFS_W-1:2*OFS_W], s_axis_tuser);
    end
    pending = expected_blocks.size();
  end

endmodule

FILE: verif/tb_grid_column_block_accumulator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_column_block_accumulator_core
// Drives hit beats and register writes into the column accumulator: a short
// directed run over the corner cases, then random phases with varied grid,
// block and extent settings and varied idling on both streams. The checker
// beside the block predicts and compares every block beat.
// ----------------------------------------------------------------------------
module tb_grid_column_block_accumulator_core;

  import gcba_pkg::*;

  localparam int NUM_PHASES  = 14;
  localparam int PHASE_HITS  = 96;
  localparam int HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_GAP   = 20;
  localparam int WD_LIMIT    = 5000;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // x_offset, y_offset, z_offset
  logic [IN_TUSER_W-1:0]  s_axis_tuser;   // species
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // bin_index, start_z, end_z, count_0, count_1, count_2, count_3
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  bit stall_hold_req;
  int quiet_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  grid_column_block_accumulator_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  gcba_block_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Watchdog: cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else if (quiet_cycles >= WD_LIMIT) begin
      $error("no beat for %0d cycles, %0d blocks outstanding", quiet_cycles, pending);
      $display("[grid_column_block_accumulator_core] ERROR");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Block receiver: random stalls, or one long hold-off on request
  initial begin
    bit hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // One hit beat, with random idle cycles ahead of it
  task automatic send_hit(input logic [OFS_W-1:0] xo, input logic [OFS_W-1:0] yo,
                          input logic [OFS_W-1:0] z, input logic [SP_W-1:0] sp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, yo, xo};
    s_axis_tuser  <= sp;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let the stream run dry before touching registers
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [BINS_W-1:0] bx, input logic [BINS_W-1:0] by,
                            input logic [OFS_W-1:0] rx, input logic [OFS_W-1:0] ry,
                            input logic [CNT_W-1:0] bs, input logic [OFS_W-1:0] mn,
                            input logic [OFS_W-1:0] mx);
    write_reg(REG_BINS_X, CFG_DATA_W'(bx));
    write_reg(REG_BINS_Y, CFG_DATA_W'(by));
    write_reg(REG_RECIP_LEN_X, rx);
    write_reg(REG_RECIP_LEN_Y, ry);
    write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(bs));
    write_reg(REG_MIN_EXTENT, mn);
    write_reg(REG_MAX_EXTENT, mx);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  // Mostly small grids so hits pile up in a few columns
  function automatic logic [BINS_W-1:0] pick_bins;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return BINS_W'(256);
      2:       return BINS_W'($urandom_range(5, 40));
      default: return BINS_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_recip;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 24'hFFFFFF;
      2:       return OFS_W'($urandom_range(0, 24'hFFFFFF));
      3:       return OFS_W'($urandom_range(1024, 200000));
      default: return RECIP_RST;
    endcase
  endfunction

  function automatic logic [OFS_W-1:0] pick_offset;
    case ($urandom_range(0, 9))
      0:       return OFS_W'($urandom_range(0, 24'hFFFFFF));
      1:       return 24'hFFFFFF;
      default: return OFS_W'($urandom_range(0, 6));
    endcase
  endfunction

  initial begin
    logic [OFS_W-1:0] mn, mx, z_now, z;
    logic [CNT_W-1:0] bs;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_we         = 1'b0;
    cfg_index      = REG_BINS_X;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_hold_req = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: corner offsets and heights, all species, unsorted hit
    set_idling(0);
    set_config(9'd16, 9'd16, RECIP_RST, RECIP_RST, 10'd2, 24'd0, 24'hFFFFFF);
    send_hit(24'd0, 24'd0, 24'd0, 2'd0);
    send_hit(24'd0, 24'd0, 24'd5, 2'd1);
    send_hit(24'hFFFFFF, 24'hFFFFFF, 24'd100, 2'd2);
    send_hit(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 2'd3);
    send_hit(24'd0, 24'd0, 24'd3, 2'd3);
    send_hit(24'd0, 24'd0, 24'd1, 2'd0);
    drain();

    // Zero bin counts, zero reciprocal, zero block size, zero-height window
    set_config(9'd0, 9'd0, 24'd0, 24'd0, 10'd0, 24'd0, 24'd0);
    send_hit(24'hFFFFFF, 24'd7, 24'd1, 2'd1);
    send_hit(24'd3, 24'hFFFFFF, 24'd1, 2'd2);
    send_hit(24'd0, 24'd0, 24'd7, 2'd3);
    send_hit(24'd9, 24'd9, 24'hFFFFFF, 2'd0);
    drain();

    // Grid larger than the store: columns past the end are dropped
    set_config(9'd32, 9'd16, 24'hFFFFFF, RECIP_RST, 10'd1, 24'd5, 24'd100);
    send_hit(24'd0, 24'd3, 24'd50, 2'd1);
    send_hit(24'd1, 24'd0, 24'd60, 2'd2);
    send_hit(24'd0, 24'hFFFFFF, 24'd200, 2'd3);
    send_hit(24'd0, 24'd2, 24'd3, 2'd0);
    drain();

    // Inverted extents: columns restart, nothing reported
    set_config(9'd16, 9'd16, RECIP_RST, RECIP_RST, 10'd1, 24'hFFFFFF, 24'd0);
    send_hit(24'd2, 24'd2, 24'hFFFFFF, 2'd0);
    send_hit(24'd2, 24'd2, 24'd0, 2'd1);
    send_hit(24'd3, 24'd1, 24'd123, 2'd2);
    drain();

    // Random phases; block size never shrinks so no column gets stranded
    bs = 10'd1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       begin mn = OFS_W'($urandom_range(100, 1000)); mx = OFS_W'($urandom_range(0, 99)); end
        1:       begin mn = OFS_W'($urandom_range(0, 30)); mx = OFS_W'($urandom_range(30, 200)); end
        2:       begin mn = '0; mx = '0; end
        3:       begin mn = '0; mx = OFS_W'($urandom_range(0, 24'hFFFFFF)); end
        default: begin mn = '0; mx = 24'hFFFFFF; end
      endcase
      // hold-off phase needs every completed block to report
      if (ph == 0) begin
        mn = '0;
        mx = 24'hFFFFFF;
      end
      if (ph == NUM_PHASES - 1)
        bs = 10'd1023;
      else if (ph > 0 && bs < 10'd8)
        bs = bs + CNT_W'($urandom_range(0, 1));
      set_config(pick_bins(), pick_bins(), pick_recip(), pick_recip(), bs, mn, mx);
      set_idling(ph % 4);
      // first phase: block size one, receiver holds off, block backs up
      if (ph == 0) stall_hold_req = 1'b1;
      z_now = OFS_W'($urandom_range(0, 24'hFFF000));
      for (int i = 0; i < PHASE_HITS; i++) begin
        z_now = z_now + OFS_W'($urandom_range(0, 12));
        z = ($urandom_range(0, 19) == 0) ? OFS_W'($urandom_range(0, 24'hFFFFFF)) : z_now;
        send_hit(pick_offset(), pick_offset(), z, SP_W'($urandom_range(0, 3)));
      end
      drain();
    end

    repeat (DRAIN_GAP) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[grid_column_block_accumulator_core] OK");
    else
      $display("[grid_column_block_accumulator_core] ERROR");
    $finish;
  end

endmodule
